// ----- hw/rtl/rpac_pkg.sv -----
// Shared constants, widths and types for the point rotation block.
// Holds the CORDIC arctangent table. No dependencies.
`timescale 1ns / 1ps

package rpac_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int COORD_BITS    = 32;

  // Only 32 table entries exist; deeper chains are not built.
  localparam int N_CELLS = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

  localparam int STAGE_W = 5;               // index into the 32-entry table
  localparam int XY_W    = 34;              // Q2.30 with headroom
  localparam int Z_W     = 34;              // units of 2^-32 turn
  localparam int TRIG_W  = 30;              // Q2.28 cos/sin, |v| <= 2^28
  localparam int D_W     = COORD_BITS + 1;  // point minus center
  localparam int PROD_W  = D_W + TRIG_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int DOT_W   = SUM_W - 28;
  localparam int TOT_W   = DOT_W + 1;
  localparam int ANGLE_W = 16;

  localparam int IN_DATA_W  = ((4 * COORD_BITS + ANGLE_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * COORD_BITS + 7) / 8) * 8;

  localparam logic signed [XY_W-1:0] GAIN_Q30 = XY_W'(652032874);
  localparam logic signed [XY_W-1:0] TRIG_RND = XY_W'(2);
  localparam logic signed [31:0]     TRIG_ONE = 32'sd268435456;
  localparam logic signed [SUM_W-1:0] DOT_RND = SUM_W'(134217728);

  // One item inside the rotation chain.
  typedef struct packed {
    logic signed [XY_W-1:0]       x;
    logic signed [XY_W-1:0]       y;
    logic signed [Z_W-1:0]        z;
    logic                         flip;
    logic signed [D_W-1:0]        dx;
    logic signed [D_W-1:0]        dy;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
  } cord_t;

  // atan(2^-i) in units of 2^-32 turn, rounded to nearest.
  function automatic logic signed [Z_W-1:0] atan_turn(input logic [STAGE_W-1:0] idx);
    logic signed [Z_W-1:0] v;
    unique case (idx)
      5'd0:  v = Z_W'(536870912);
      5'd1:  v = Z_W'(316933406);
      5'd2:  v = Z_W'(167458907);
      5'd3:  v = Z_W'(85004756);
      5'd4:  v = Z_W'(42667331);
      5'd5:  v = Z_W'(21354465);
      5'd6:  v = Z_W'(10679838);
      5'd7:  v = Z_W'(5340245);
      5'd8:  v = Z_W'(2670163);
      5'd9:  v = Z_W'(1335087);
      5'd10: v = Z_W'(667544);
      5'd11: v = Z_W'(333772);
      5'd12: v = Z_W'(166886);
      5'd13: v = Z_W'(83443);
      5'd14: v = Z_W'(41722);
      5'd15: v = Z_W'(20861);
      5'd16: v = Z_W'(10430);
      5'd17: v = Z_W'(5215);
      5'd18: v = Z_W'(2608);
      5'd19: v = Z_W'(1304);
      5'd20: v = Z_W'(652);
      5'd21: v = Z_W'(326);
      5'd22: v = Z_W'(163);
      5'd23: v = Z_W'(81);
      5'd24: v = Z_W'(41);
      5'd25: v = Z_W'(20);
      5'd26: v = Z_W'(10);
      5'd27: v = Z_W'(5);
      5'd28: v = Z_W'(3);
      5'd29: v = Z_W'(1);
      5'd30: v = Z_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- hw/rtl/rotate_point_about_center.sv -----
// Top level: rotation of a point about a center by a binary angle.
// Depends on rpac_pkg, rpac_cell and rpac_post.
`timescale 1ns / 1ps

// Usage
//   Slave side (s_axis_*): one request per point: point, center and angle,
//   packed in s_axis_tdata. Master side (m_axis_*): one result per request,
//   rotated point in m_axis_tdata, saturation flag in m_axis_tuser.
//   Coordinates are signed Q16.16; the angle counts 65536 units per turn,
//   counterclockwise.
// Timing
//   From accept to m_axis_tvalid a request passes one entry register, one
//   register per CORDIC cell, then trig rounding, multiply, sum/round and
//   saturate stages.
//   Throughput is one request per cycle while m_axis_tready stays high; every
//   stage is a register with its own valid, so the pipeline runs back to back.
// Reset
//   rst (synchronous, active high) empties every stage; no payload is cleared.
// Stalls
//   When m_axis_tready is low the final result holds. Stages upstream keep
//   moving until they close up behind it, and s_axis_tready drops only once
//   the entry register is full and cannot move on.

module rotate_point_about_center
  import rpac_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // point_x, point_y, center_x, center_y, turn_angle (lowest bit up)
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // rotated_x, rotated_y (lowest bit up)
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // clipped
  output logic [0:0]            m_axis_tuser
);

  // Unpacked request fields
  logic signed [COORD_BITS-1:0] point_x, point_y, center_x, center_y;
  logic [ANGLE_W-1:0]           turn_angle;

  assign point_x    = s_axis_tdata[COORD_BITS-1:0];
  assign point_y    = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
  assign center_x   = s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
  assign center_y   = s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS];
  assign turn_angle = s_axis_tdata[4*COORD_BITS+ANGLE_W-1:4*COORD_BITS];

  // Chain links: index 0 is the entry register, N_CELLS is the last cell.
  logic  link_valid [0:N_CELLS];
  logic  link_ready [0:N_CELLS];
  cord_t link_data  [0:N_CELLS];

  // Entry: quadrant fold and offsets from the center.
  // Angles in the middle half turn are moved by half a turn and the
  // trig results negated later, leaving a residual in [-1/4, 1/4) turn.
  logic                       fold;
  logic signed [ANGLE_W-1:0]  resid;
  cord_t                      entry_next;
  logic                       entry_valid;
  cord_t                      entry_data;

  always_comb begin
    fold                = turn_angle[15] ^ turn_angle[14];
    resid               = {turn_angle[15] ^ fold, turn_angle[14:0]};
    entry_next.x        = GAIN_Q30;
    entry_next.y        = '0;
    entry_next.z        = {{(Z_W-32){resid[ANGLE_W-1]}}, resid, 16'b0};
    entry_next.flip     = fold;
    entry_next.dx       = D_W'(point_x) - D_W'(center_x);
    entry_next.dy       = D_W'(point_y) - D_W'(center_y);
    entry_next.cx       = center_x;
    entry_next.cy       = center_y;
  end

  assign s_axis_tready = !entry_valid || link_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
    end else if (s_axis_tready) begin
      entry_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      entry_data <= entry_next;
    end
  end

  assign link_valid[0] = entry_valid;
  assign link_data[0]  = entry_data;

  // Row of CORDIC cells, one step each
  for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
    rpac_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .stage     (STAGE_W'(i)),
      .in_valid  (link_valid[i]),
      .in_ready  (link_ready[i]),
      .in_data   (link_data[i]),
      .out_valid (link_valid[i+1]),
      .out_ready (link_ready[i+1]),
      .out_data  (link_data[i+1])
    );
  end

  // Trig format, products, rounding and saturation
  logic signed [COORD_BITS-1:0] rotated_x, rotated_y;
  logic                         clipped;

  rpac_post u_post (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (link_valid[N_CELLS]),
    .in_ready  (link_ready[N_CELLS]),
    .in_data   (link_data[N_CELLS]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .rotated_x (rotated_x),
    .rotated_y (rotated_y),
    .clipped   (clipped)
  );

  assign m_axis_tdata    = OUT_DATA_W'({rotated_y, rotated_x});
  assign m_axis_tuser[0] = clipped;

  // Checks
  localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  // A clipped result has at least one coordinate at an end of the range.
  a_clip_at_rail: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && clipped |->
      rotated_x == CMAX || rotated_x == CMIN || rotated_y == CMAX || rotated_y == CMIN)
    else $error("clipped set on a result that is not saturated");

  // Backpressure at the input only when the entry register is occupied.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> entry_valid)
    else $error("input stalled with empty entry stage");

  // Reset leaves no result behind.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

// ----- hw/rtl/rpac_cell.sv -----
// One CORDIC rotation step with its own register stage and handshake.
// Depends on rpac_pkg.
`timescale 1ns / 1ps

module rpac_cell
  import rpac_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [STAGE_W-1:0] stage,     // tied to a constant per cell
  input  logic               in_valid,
  output logic               in_ready,
  input  cord_t              in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cord_t              out_data
);

  cord_t                 step;
  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;
  logic signed [Z_W-1:0]  ang;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    xs   = in_data.x >>> stage;
    ys   = in_data.y >>> stage;
    ang  = atan_turn(stage);
    step = in_data;
    if (!in_data.z[Z_W-1]) begin
      step.x = in_data.x - ys;
      step.y = in_data.y + xs;
      step.z = in_data.z - ang;
    end else begin
      step.x = in_data.x + ys;
      step.y = in_data.y - xs;
      step.z = in_data.z + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= step;
    end
  end

endmodule

// ----- hw/rtl/rpac_post.sv -----
// Trig rounding, products, rounding of the dot sums and center add with saturation.
// Four register stages after the CORDIC chain. Depends on rpac_pkg.
`timescale 1ns / 1ps

module rpac_post
  import rpac_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  cord_t                        in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] rotated_x,
  output logic signed [COORD_BITS-1:0] rotated_y,
  output logic                         clipped
);

  // stage valids: t = trig, p = products, s = sums, out = final
  logic v_t, v_p, v_s;
  logic r_t, r_p, r_s, r_o;

  logic signed [TRIG_W-1:0]     cos_t, sin_t;
  logic signed [D_W-1:0]        dx_t, dy_t;
  logic signed [COORD_BITS-1:0] cx_t, cy_t, cx_p, cy_p, cx_s, cy_s;
  logic signed [PROD_W-1:0]     dxc_p, dys_p, dxs_p, dyc_p;
  logic signed [DOT_W-1:0]      dot_x_s, dot_y_s;

  logic signed [XY_W-1:0]   cr, sr;
  logic signed [31:0]       cr_c, sr_c;
  logic signed [TRIG_W-1:0] cos_next, sin_next;
  logic signed [SUM_W-1:0]  sum_x, sum_y;
  logic signed [TOT_W-1:0]  tot_x, tot_y;
  logic signed [COORD_BITS-1:0] sat_x, sat_y;
  logic                     ovf_x, ovf_y;

  assign r_o      = !out_valid || out_ready;
  assign r_s      = !v_s || r_o;
  assign r_p      = !v_p || r_s;
  assign r_t      = !v_t || r_p;
  assign in_ready = r_t;

  function automatic logic signed [31:0] clamp_one(input logic signed [XY_W-1:0] v);
    logic signed [31:0] r;
    if (v > XY_W'(TRIG_ONE)) begin
      r = TRIG_ONE;
    end else if (v < -XY_W'(TRIG_ONE)) begin
      r = -TRIG_ONE;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] sat_coord(
    input logic signed [TOT_W-1:0] v
  );
    logic signed [COORD_BITS-1:0] r;
    if (v[TOT_W-1:COORD_BITS-1] == '0 || v[TOT_W-1:COORD_BITS-1] == '1) begin
      r = v[COORD_BITS-1:0];
    end else if (v[TOT_W-1]) begin
      r = {1'b1, {(COORD_BITS-1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_BITS-1){1'b1}}};
    end
    return r;
  endfunction

  always_comb begin
    cr   = (in_data.x + TRIG_RND) >>> 2;
    sr   = (in_data.y + TRIG_RND) >>> 2;
    cr_c = clamp_one(cr);
    sr_c = clamp_one(sr);
    if (in_data.flip) begin
      cos_next = -TRIG_W'(cr_c);
      sin_next = -TRIG_W'(sr_c);
    end else begin
      cos_next = TRIG_W'(cr_c);
      sin_next = TRIG_W'(sr_c);
    end
    sum_x = SUM_W'(dxc_p) - SUM_W'(dys_p) + DOT_RND;
    sum_y = SUM_W'(dxs_p) + SUM_W'(dyc_p) + DOT_RND;
    tot_x = TOT_W'(cx_s) + TOT_W'(dot_x_s);
    tot_y = TOT_W'(cy_s) + TOT_W'(dot_y_s);
    sat_x = sat_coord(tot_x);
    sat_y = sat_coord(tot_y);
    ovf_x = (tot_x != TOT_W'(sat_x));
    ovf_y = (tot_y != TOT_W'(sat_y));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_t       <= 1'b0;
      v_p       <= 1'b0;
      v_s       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (r_t) begin
        v_t <= in_valid;
      end
      if (r_p) begin
        v_p <= v_t;
      end
      if (r_s) begin
        v_s <= v_p;
      end
      if (r_o) begin
        out_valid <= v_s;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r_t && in_valid) begin
      cos_t <= cos_next;
      sin_t <= sin_next;
      dx_t  <= in_data.dx;
      dy_t  <= in_data.dy;
      cx_t  <= in_data.cx;
      cy_t  <= in_data.cy;
    end
    if (r_p && v_t) begin
      dxc_p <= PROD_W'(dx_t) * PROD_W'(cos_t);
      dys_p <= PROD_W'(dy_t) * PROD_W'(sin_t);
      dxs_p <= PROD_W'(dx_t) * PROD_W'(sin_t);
      dyc_p <= PROD_W'(dy_t) * PROD_W'(cos_t);
      cx_p  <= cx_t;
      cy_p  <= cy_t;
    end
    if (r_s && v_p) begin
      dot_x_s <= sum_x[SUM_W-1:28];
      dot_y_s <= sum_y[SUM_W-1:28];
      cx_s    <= cx_p;
      cy_s    <= cy_p;
    end
    if (r_o && v_s) begin
      rotated_x <= sat_x;
      rotated_y <= sat_y;
      clipped   <= ovf_x || ovf_y;
    end
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for rotate_point_about_center: directed and random rotation
// requests on the stream ports, checked against a CORDIC model kept in this file.
// Depends on rpac_pkg and the rotate_point_about_center RTL.

module testbench;
  import rpac_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 7;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int TAIL_CYCLES  = N_CELLS + 5 + 10;

  // binary angle landmarks, 65536 units per turn
  localparam longint QUARTER_TURN  = 16384;
  localparam longint HALF_TURN     = 32768;
  localparam longint THREE_QUARTER = 49152;
  localparam longint FULL_TURN     = 65536;

  localparam longint START_GAIN_Q30 = 652032874;   // 1/K, CORDIC gain folded in
  localparam longint UNIT_Q28       = 268435456;
  localparam longint HALF_LSB_Q28   = 134217728;
  localparam longint SMALL_SPAN     = 64'sh40_0000; // +-64.0 in Q16.16

  localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    coord_t cy;
    coord_t cx;
    coord_t py;
    coord_t px;
  } rot_req_t;

  typedef struct packed {
    logic   clipped;
    coord_t ry;
    coord_t rx;
  } rot_res_t;

  typedef enum int {PACE_RANDOM, PACE_STEADY, PACE_CHOPPY} pace_t;

  // atan(2^-i) in 2^-32 turn units
  longint arctan_turn32 [32] = '{
    536870912, 316933406, 167458907, 85004756,
    42667331, 21354465, 10679838, 5340245,
    2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861,
    10430, 5215, 2608, 1304,
    652, 326, 163, 81,
    41, 20, 10, 5,
    3, 1, 1, 0
  };

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [0:0]            m_axis_tuser;

  rot_res_t rotated_due [$];   // predicted results, oldest first
  int       errors = 0;
  pace_t    tx_pace = PACE_RANDOM;
  pace_t    rx_pace = PACE_RANDOM;
  int       stall_left = 0;

  rotate_point_about_center dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  initial begin : watchdog
    int cyc;
    cyc = 0;
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("rotate_point_about_center verification failed");
    $finish;
  end

  // ---------------------------------------------------------------- model

  // Q2.28 cos/sin of a binary angle: fold to +-1/4 turn, unrolled CORDIC,
  // round to Q2.28, clamp, unfold.
  function automatic void cordic_cos_sin(input logic [ANGLE_W-1:0] ang,
                                         output longint cos_q28, output longint sin_q28);
    longint a, x, y, z, xs, ys;
    bit     flip;
    int     i;
    a = longint'(ang);
    flip = (a >= QUARTER_TURN) && (a < THREE_QUARTER);
    if (flip) begin
      a = a - HALF_TURN;
    end else if (a >= THREE_QUARTER) begin
      a = a - FULL_TURN;
    end
    z = a <<< 16;
    x = START_GAIN_Q30;
    y = 0;
    for (i = 0; i < N_CELLS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - arctan_turn32[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + arctan_turn32[i];
      end
    end
    x = (x + 2) >>> 2;
    y = (y + 2) >>> 2;
    if (x > UNIT_Q28) x = UNIT_Q28;
    if (x < -UNIT_Q28) x = -UNIT_Q28;
    if (y > UNIT_Q28) y = UNIT_Q28;
    if (y < -UNIT_Q28) y = -UNIT_Q28;
    cos_q28 = flip ? -x : x;
    sin_q28 = flip ? -y : y;
  endfunction

  function automatic coord_t saturate_coord(input longint v, inout logic hit);
    longint top, bottom;
    top    = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    bottom = -top - 1;
    if (v > top) begin
      hit = 1'b1;
      return COORD_MAX;
    end
    if (v < bottom) begin
      hit = 1'b1;
      return COORD_MIN;
    end
    return coord_t'(v);
  endfunction

  function automatic rot_res_t predict_rotation(input rot_req_t r);
    longint   c, s, dx, dy, sum_x, sum_y;
    rot_res_t res;
    cordic_cos_sin(r.angle, c, s);
    dx = longint'(r.px) - longint'(r.cx);
    dy = longint'(r.py) - longint'(r.cy);
    // exact products, round half up to Q16.16, center added exactly
    sum_x = longint'(r.cx) + ((dx * c - dy * s + HALF_LSB_Q28) >>> 28);
    sum_y = longint'(r.cy) + ((dx * s + dy * c + HALF_LSB_Q28) >>> 28);
    res.clipped = 1'b0;
    res.rx = saturate_coord(sum_x, res.clipped);
    res.ry = saturate_coord(sum_y, res.clipped);
    return res;
  endfunction

  // ---------------------------------------------------------------- sink side

  // Mostly short stalls, a few long ones; none at all in steady mode.
  always @(posedge clk) begin
    if (rx_pace == PACE_STEADY) begin
      m_axis_tready <= 1'b1;
      stall_left    <= 0;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if ($urandom_range(0, 99) < ((rx_pace == PACE_CHOPPY) ? 45 : 12)) begin
      m_axis_tready <= 1'b0;
      stall_left    <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) - 1
                                                   : $urandom_range(1, 3) - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Each accepted result against the oldest prediction.
  always @(posedge clk) begin
    rot_res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (rotated_due.size() == 0) begin
        $display("%0t: result with no request pending: expected none, actual %h/%h",
                 $time, m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        want = rotated_due.pop_front();
        if (m_axis_tdata[COORD_BITS-1:0] !== want.rx) begin
          $display("%0t: rotated_x expected %h actual %h",
                   $time, want.rx, m_axis_tdata[COORD_BITS-1:0]);
          errors++;
        end
        if (m_axis_tdata[2*COORD_BITS-1:COORD_BITS] !== want.ry) begin
          $display("%0t: rotated_y expected %h actual %h",
                   $time, want.ry, m_axis_tdata[2*COORD_BITS-1:COORD_BITS]);
          errors++;
        end
        if (m_axis_tuser[0] !== want.clipped) begin
          $display("%0t: clipped expected %b actual %b",
                   $time, want.clipped, m_axis_tuser[0]);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- source side

  // One request: optional idle gap, then hold valid until accepted.
  task automatic send_request(input rot_req_t r);
    int gap;
    gap = 0;
    if (tx_pace != PACE_STEADY) begin
      case ($urandom_range(0, 9))
        0, 1, 2:  gap = $urandom_range(1, 3);
        3:        gap = ($urandom_range(0, 2) == 0) ? $urandom_range(8, 40) : 0;
        default:  gap = 0;
      endcase
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'({r.angle, r.cy, r.cx, r.py, r.px});
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    rotated_due.push_back(predict_rotation(r));
  endtask

  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (rotated_due.size() != 0) @(posedge clk);
  endtask

  function automatic rot_req_t make_req(input coord_t px, input coord_t py, input coord_t cx,
                                        input coord_t cy, input logic [ANGLE_W-1:0] angle);
    rot_req_t r;
    r.px = px;
    r.py = py;
    r.cx = cx;
    r.cy = cy;
    r.angle = angle;
    return r;
  endfunction

  function automatic coord_t random_coord();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       return COORD_MAX;
          1:       return COORD_MIN;
          2:       return '0;
          3:       return coord_t'(1);
          default: return coord_t'(-1);
        endcase
      end
      1, 2, 3: return coord_t'({$urandom, $urandom});
      default: return coord_t'(longint'($urandom_range(0, 2 * SMALL_SPAN)) - SMALL_SPAN);
    endcase
  endfunction

  // Mostly full-range angles; some hug the quadrant fold points.
  function automatic rot_req_t random_request();
    rot_req_t r;
    r.px = random_coord();
    r.py = random_coord();
    r.cx = random_coord();
    r.cy = random_coord();
    if ($urandom_range(0, 3) == 0) begin
      // point close to the center, the common geometric case
      r.px = coord_t'(longint'(r.cx) + longint'($urandom_range(0, 2 * SMALL_SPAN)) - SMALL_SPAN);
      r.py = coord_t'(longint'(r.cy) + longint'($urandom_range(0, 2 * SMALL_SPAN)) - SMALL_SPAN);
    end
    if ($urandom_range(0, 4) == 0) begin
      r.angle = ANGLE_W'(longint'($urandom_range(0, 3)) * QUARTER_TURN
                         + longint'($urandom_range(0, 4)) - 2);
    end else begin
      r.angle = ANGLE_W'($urandom_range(0, 65535));
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- tests

  // Quadrant edges and the fold on a unit-sized offset.
  task automatic test_angle_corners();
    longint corners [12] = '{0, 1, 8192, 16383, 16384, 16385,
                             32767, 32768, 32769, 49151, 49152, 65535};
    int k;
    for (k = 0; k < 12; k++) begin
      send_request(make_req(coord_t'(32'sh0001_4000), coord_t'(-32'sh0000_4000),
                            coord_t'(32'sh0000_4000), coord_t'(-32'sh0000_c000),
                            ANGLE_W'(corners[k])));
    end
  endtask

  // Largest offsets, saturation both ways, zero offset, LSB rounding.
  task automatic test_coord_extremes();
    send_request(make_req('0, '0, '0, '0, '0));
    send_request(make_req(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, ANGLE_W'(12345)));
    send_request(make_req(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, '0));
    send_request(make_req(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, ANGLE_W'(HALF_TURN)));
    send_request(make_req(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, ANGLE_W'(HALF_TURN)));
    send_request(make_req(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, ANGLE_W'(QUARTER_TURN)));
    send_request(make_req(COORD_MIN, COORD_MAX, '0, '0, ANGLE_W'(THREE_QUARTER)));
    send_request(make_req(coord_t'(-1), coord_t'(-1), coord_t'(1), coord_t'(1),
                          ANGLE_W'(FULL_TURN - 1)));
    send_request(make_req(COORD_MAX, '0, '0, '0, ANGLE_W'(8192)));
    send_request(make_req(coord_t'(32'sh4000_0000), coord_t'(-32'sh4000_0000),
                          coord_t'(-32'sh2000_0000), coord_t'(32'sh3000_0000),
                          ANGLE_W'(24576)));
  endtask

  task automatic test_random_mix(input int count);
    int k;
    for (k = 0; k < count; k++) send_request(random_request());
  endtask

  // Full rate on both sides.
  task automatic test_back_to_back(input int count);
    int k;
    tx_pace = PACE_STEADY;
    rx_pace = PACE_STEADY;
    for (k = 0; k < count; k++) send_request(random_request());
    tx_pace = PACE_RANDOM;
    rx_pace = PACE_RANDOM;
  endtask

  // Bursts separated by a full drain of the pipeline.
  task automatic test_drain_pause(input int bursts, input int burst_len);
    int b, k;
    for (b = 0; b < bursts; b++) begin
      for (k = 0; k < burst_len; k++) send_request(random_request());
      wait_for_drain();
    end
  endtask

  // Slow sink with a fast source, so the stall backs up to s_axis_tready.
  task automatic test_choppy_sink(input int count);
    int k;
    tx_pace = PACE_STEADY;
    rx_pace = PACE_CHOPPY;
    for (k = 0; k < count; k++) send_request(random_request());
    tx_pace = PACE_RANDOM;
    rx_pace = PACE_RANDOM;
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_angle_corners();
    test_coord_extremes();
    test_random_mix(300);
    test_back_to_back(120);
    test_drain_pause(4, 20);
    test_choppy_sink(150);
    test_random_mix(230);

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("rotate_point_about_center verification clean");
    end else begin
      $display("rotate_point_about_center verification failed");
    end
    $finish;
  end

endmodule
